FILE: sv/itrs_pkg.sv
package itrs_pkg;

    localparam int unsigned VALUE_WIDTH_DEF = 32;

    localparam logic [5:0] RADIX_RESET   = 6'd10;
    localparam logic [5:0] RADIX_MIN     = 6'd2;
    localparam logic [5:0] RADIX_MAX     = 6'd36;
    localparam logic [6:0] LETTER_OFFSET = 7'd55;
    localparam logic [6:0] DIGIT_BASE    = 7'h30;  // '0'
    localparam logic [6:0] MINUS_SIGN    = 7'h2D;  // '-'
    localparam logic [5:0] DECIMAL_LIMIT = 6'd10;

    // Microcode address
    typedef logic [2:0] step_t;

    localparam step_t S_IDLE   = 3'd0;
    localparam step_t S_DINIT  = 3'd1;
    localparam step_t S_DSTEP  = 3'd2;
    localparam step_t S_DSTORE = 3'd3;
    localparam step_t S_CHECK  = 3'd4;
    localparam step_t S_SIGN   = 3'd5;
    localparam step_t S_READ   = 3'd6;
    localparam step_t S_EMIT   = 3'd7;

    // What a step waits for before it fires
    typedef enum logic [1:0] {
        HOLD_NONE = 2'd0,
        HOLD_IN   = 2'd1,
        HOLD_OUT  = 2'd2
    } hold_t;

    // Jump condition, evaluated when the step fires
    typedef enum logic [2:0] {
        BR_NEVER       = 3'd0,
        BR_BITS_LEFT   = 3'd1,
        BR_MAG_NZ      = 3'd2,
        BR_NOT_NEG     = 3'd3,
        BR_DIGITS_LEFT = 3'd4
    } branch_t;

    typedef struct packed {
        hold_t   hold_on;
        branch_t br;
        step_t   jump;
        step_t   next;
        logic    ld_in;
        logic    div_init;
        logic    div_step;
        logic    store;
        logic    emit_sign;
        logic    rd;
        logic    emit_dig;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t pc);
        ucode_t w;
        w = '{hold_on: HOLD_NONE, br: BR_NEVER, jump: S_IDLE, next: S_IDLE,
              default: 1'b0};
        case (pc)
            S_IDLE: begin
                w.hold_on = HOLD_IN;
                w.ld_in   = 1'b1;
                w.next    = S_DINIT;
            end
            S_DINIT: begin
                w.div_init = 1'b1;
                w.next     = S_DSTEP;
            end
            S_DSTEP: begin
                w.div_step = 1'b1;
                w.br       = BR_BITS_LEFT;
                w.jump     = S_DSTEP;
                w.next     = S_DSTORE;
            end
            S_DSTORE: begin
                w.store = 1'b1;
                w.br    = BR_MAG_NZ;
                w.jump  = S_DINIT;
                w.next  = S_CHECK;
            end
            S_CHECK: begin
                w.br   = BR_NOT_NEG;
                w.jump = S_READ;
                w.next = S_SIGN;
            end
            S_SIGN: begin
                w.hold_on   = HOLD_OUT;
                w.emit_sign = 1'b1;
                w.next      = S_READ;
            end
            S_READ: begin
                w.rd   = 1'b1;
                w.next = S_EMIT;
            end
            S_EMIT: begin
                w.hold_on  = HOLD_OUT;
                w.emit_dig = 1'b1;
                w.br       = BR_DIGITS_LEFT;
                w.jump     = S_READ;
                w.next     = S_IDLE;
            end
            default: begin
                w.next = S_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic [6:0] digit_char(input logic [5:0] d);
        return (d < DECIMAL_LIMIT) ? ({1'b0, d} + DIGIT_BASE) : ({1'b0, d} + LETTER_OFFSET);
    endfunction

    function automatic logic [5:0] clamp_radix(input logic [5:0] r);
        if (r < RADIX_MIN) begin
            return RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            return RADIX_MAX;
        end
        return r;
    endfunction

endpackage

FILE: sv/integer_to_radix_string_core.sv
// Per digit, a bit-serial restoring divider (one bit a cycle) divides the magnitude by the
//   radix and stores the remainder; then '-' goes first when negative, then the digits,
//   most significant first, each held while the output register is full. A new request is
//   taken only in idle, once the last character of the previous number is in the output register.
// Reset: aresetn synchronous, active low; clears sequencer, output valid and radix (back to 10).
module integer_to_radix_string_core #(
    parameter int unsigned VALUE_WIDTH = itrs_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // radix register, 6 bits
    input  logic                                  cfg_wr_en,
    input  logic [5:0]                            cfg_wr_data,
    // input requests
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      s_tdata,   // [VALUE_WIDTH-1:0] value, rest 0
    // output characters
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [7:0]                            m_tdata,   // [6:0] character, [7] zero
    output logic                                  m_tlast    // last character of the number
);
    import itrs_pkg::*;

    localparam int unsigned AW = $clog2(VALUE_WIDTH);      // digit store / bit counter index
    localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);  // digit count, holds VALUE_WIDTH

    // ---------------------------------------------------------------------------------------
    // Sequencer: program counter into the microcode ROM
    // ---------------------------------------------------------------------------------------
    step_t  pc_reg, pc_next;
    ucode_t uc;
    logic   fire;
    logic   take;

    // ---------------------------------------------------------------------------------------
    // Datapath state
    // ---------------------------------------------------------------------------------------
    logic [5:0]             radix_reg;      // stored already clamped to 2..36
    logic [VALUE_WIDTH-1:0] mag_reg;        // dividend, quotient shifts in from the bottom
    logic [5:0]             rem_reg;        // partial remainder, always below radix
    logic [AW-1:0]          bit_cnt_reg;
    logic [CW-1:0]          dig_cnt_reg;
    logic                   neg_reg;        // '-' still owed
    logic [5:0]             digit_mem [VALUE_WIDTH];
    logic [5:0]             rd_data_reg;

    logic                   out_valid_reg;
    logic [6:0]             out_char_reg;
    logic                   out_last_reg;
    logic                   out_free;

    logic [VALUE_WIDTH-1:0] in_val;
    logic [6:0]             trial;
    logic                   trial_ge;
    logic [CW-1:0]          rd_idx;

    assign uc       = ucode_rom(pc_reg);
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        case (uc.hold_on)
            HOLD_NONE: fire = 1'b1;
            HOLD_IN:   fire = s_tvalid;
            HOLD_OUT:  fire = out_free;
            default:   fire = 1'b0;
        endcase
    end

    // conditional jump select
    always_comb begin
        case (uc.br)
            BR_NEVER:       take = 1'b0;
            BR_BITS_LEFT:   take = (bit_cnt_reg != '0);
            BR_MAG_NZ:      take = (mag_reg != '0);
            BR_NOT_NEG:     take = !neg_reg;
            BR_DIGITS_LEFT: take = (dig_cnt_reg != '0);
            default:        take = 1'b0;
        endcase
    end

    always_comb begin
        pc_next = pc_reg;
        if (fire) begin
            pc_next = take ? uc.jump : uc.next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= S_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign s_tready = (uc.hold_on == HOLD_IN);

    // ---------------------------------------------------------------------------------------
    // Radix register
    // ---------------------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_wr_en) begin
            radix_reg <= clamp_radix(cfg_wr_data);
        end
    end

    // ---------------------------------------------------------------------------------------
    // Restoring divider: one quotient bit per DSTEP
    // ---------------------------------------------------------------------------------------
    assign in_val   = s_tdata[VALUE_WIDTH-1:0];
    assign trial    = {rem_reg, mag_reg[VALUE_WIDTH-1]};
    assign trial_ge = (trial >= {1'b0, radix_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neg_reg     <= 1'b0;
            mag_reg     <= '0;
            rem_reg     <= '0;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end else if (fire) begin
            if (uc.ld_in) begin
                neg_reg     <= in_val[VALUE_WIDTH-1];
                // two's complement negate; the most negative value maps onto itself unsigned
                mag_reg     <= in_val[VALUE_WIDTH-1] ? (~in_val + 1'b1) : in_val;
                dig_cnt_reg <= '0;
            end
            if (uc.div_init) begin
                rem_reg     <= '0;
                bit_cnt_reg <= AW'(VALUE_WIDTH - 1);
            end
            if (uc.div_step) begin
                rem_reg     <= trial_ge ? 6'(trial - {1'b0, radix_reg}) : trial[5:0];
                mag_reg     <= {mag_reg[VALUE_WIDTH-2:0], trial_ge};
                bit_cnt_reg <= bit_cnt_reg - 1'b1;
            end
            if (uc.store) begin
                dig_cnt_reg <= dig_cnt_reg + 1'b1;
            end
            if (uc.emit_sign) begin
                neg_reg <= 1'b0;
            end
            if (uc.rd) begin
                dig_cnt_reg <= rd_idx;
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // Digit store, least significant digit at entry 0; read back top down
    // ---------------------------------------------------------------------------------------
    assign rd_idx = dig_cnt_reg - 1'b1;

    always_ff @(posedge aclk) begin
        if (fire && uc.store) begin
            digit_mem[dig_cnt_reg[AW-1:0]] <= rem_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && uc.rd) begin
            rd_data_reg <= digit_mem[rd_idx[AW-1:0]];
        end
    end

    // ---------------------------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && (uc.emit_sign || uc.emit_dig)) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && uc.emit_sign) begin
            out_char_reg <= MINUS_SIGN;
            out_last_reg <= 1'b0;
        end else if (fire && uc.emit_dig) begin
            out_char_reg <= digit_char(rd_data_reg);
            out_last_reg <= (dig_cnt_reg == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tlast  = out_last_reg;

    // ---------------------------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------------------------
    a_radix_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (radix_reg >= RADIX_MIN) && (radix_reg <= RADIX_MAX))
        else $error("radix register out of range");

    a_rem_below_radix: assert property (@(posedge aclk) disable iff (!aresetn)
        ((pc_reg == S_DSTEP) || (pc_reg == S_DSTORE)) |-> (rem_reg < radix_reg))
        else $error("partial remainder not below radix");

    a_dig_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dig_cnt_reg <= CW'(VALUE_WIDTH))
        else $error("digit count overflow");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && uc.emit_dig && (dig_cnt_reg == '0)) |=> (pc_reg == S_IDLE))
        else $error("sequencer did not return to idle after last character");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !(fire && (uc.emit_sign || uc.emit_dig)))
        else $error("output register loaded while holding a character");

endmodule
